// ===== design/fcdma_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package fcdma_pkg;

  localparam int NUM_CHANNELS = 4;
  localparam int CH_W = 2;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_CARD  = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  reg_addr;
    logic        access_word;
    logic [31:0] write_data;
  } item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        access_error;
    logic        copy_valid;
    logic [31:0] copy_src;
    logic [31:0] copy_dst;
    logic        copy_is_word;
    logic        irq_valid;
    logic [1:0]  irq_channel;
    logic        last;
  } result_t;

  typedef enum logic [0:0] {
    ST_IDLE = 1'b0,
    ST_CARD = 1'b1
  } state_t;

  localparam logic [21:0] COUNT_ZERO_MEANS = 22'h200000;
  localparam logic [7:0] ADDR_LO   = 8'hB0;
  localparam logic [7:0] ADDR_HI   = 8'hEF;
  localparam logic [7:0] ADDR_FILL = 8'hE0;
  localparam logic [7:0] OFF_SRC   = 8'hB0;
  localparam logic [7:0] OFF_DST   = 8'hB4;
  localparam logic [7:0] OFF_CNT   = 8'hB8;
  localparam logic [7:0] OFF_HIGH  = 8'hBA;
  localparam logic [2:0] SYNC_NOW  = 3'd0;
  localparam logic [2:0] SYNC_CARD = 3'd5;

  function automatic logic [31:0] step_of(input logic [1:0] mode, input logic is_dst,
                                          input logic [31:0] size);
    case (mode)
      2'd0: step_of = size;
      2'd1: step_of = 32'd0 - size;
      2'd2: step_of = 32'd0;
      default: step_of = is_dst ? size : 32'd0;
    endcase
  endfunction

endpackage
`default_nettype wire

// ===== design/four_channel_dma_controller.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Four-channel DMA request generator.
// Input stream s_axis: one command a transfer (register read/write, transfer
// tick, card word ready). Output stream m_axis: result items; tlast marks the
// last result of a command. Register accesses and ticks give one result;
// a card-ready command gives one result per enabled card channel (at least one).
// Commands pass a two-entry queue into the engine. The engine takes one
// register access or tick per cycle while its output register is free or
// being read. A card-ready command holds the engine while it takes the
// command and then visits each channel in turn. A single output register
// holds each result; when m_axis_tready is low the engine holds and the
// queue fills, then s_axis_tready drops.
// Synchronous reset clears the channel registers, queue pointers and valid flags; every channel comes up disabled.
module four_channel_dma_controller (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // [7:0] reg_addr, [8] access_word, [40:9] write_data, rest zero
  input  wire logic [47:0]  s_axis_tdata,
  // command
  input  wire logic [1:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // [31:0] read_data, [32] access_error, [33] copy_valid, [65:34] copy_src,
  // [97:66] copy_dst, [98] copy_is_word, [99] irq_valid, [101:100] irq_channel
  output logic [103:0]      m_axis_tdata,
  output logic              m_axis_tlast
);
  import fcdma_pkg::*;

  item_t   in_item, q_item;
  result_t res;
  logic    q_valid, q_ready;

  assign in_item.command     = s_axis_tuser;
  assign in_item.reg_addr    = s_axis_tdata[7:0];
  assign in_item.access_word = s_axis_tdata[8];
  assign in_item.write_data  = s_axis_tdata[40:9];

  fcdma_fifo u_fifo (
    .clk, .rst,
    .in_item(in_item), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .out_item(q_item), .out_valid(q_valid), .out_ready(q_ready)
  );

  logic e_ready;
  fcdma_engine u_engine (
    .clk, .rst,
    .in_item(q_item), .in_valid(q_valid), .in_ready(e_ready),
    .res(res), .res_valid(m_axis_tvalid), .res_ready(m_axis_tready)
  );

  assign q_ready = e_ready;

  assign m_axis_tdata = {2'b00, res.irq_channel, res.irq_valid, res.copy_is_word,
                         res.copy_dst, res.copy_src, res.copy_valid,
                         res.access_error, res.read_data};
  assign m_axis_tlast = res.last;
endmodule
`default_nettype wire

// ===== design/fcdma_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
module fcdma_fifo (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire fcdma_pkg::item_t in_item,
  input  wire logic             in_valid,
  output logic                  in_ready,
  output fcdma_pkg::item_t      out_item,
  output logic                  out_valid,
  input  wire logic             out_ready
);
  import fcdma_pkg::*;

  item_t      mem [2];
  logic       wp, rp;
  logic [1:0] cnt;

  assign in_ready  = (cnt != 2'd2);
  assign out_valid = (cnt != 2'd0);
  assign out_item  = mem[rp];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) mem[wp] <= in_item;
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (in_valid && in_ready) wp <= ~wp;
      if (out_valid && out_ready) rp <= ~rp;
      cnt <= cnt + {1'b0, in_valid && in_ready} - {1'b0, out_valid && out_ready};
    end
  end

  assert property (@(posedge clk) disable iff (rst) cnt <= 2'd2)
    else $error("queue overfilled");
  assert property (@(posedge clk) disable iff (rst)
    (cnt == 2'd0) |-> !(out_valid))
    else $error("empty queue valid");
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !(out_valid && out_ready)) |=> cnt == $past(cnt) + 2'd1)
    else $error("count lost a push");
endmodule
`default_nettype wire

// ===== design/fcdma_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
module fcdma_engine (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire fcdma_pkg::item_t in_item,
  input  wire logic             in_valid,
  output logic                  in_ready,
  output fcdma_pkg::result_t    res,
  output logic                  res_valid,
  input  wire logic             res_ready
);
  import fcdma_pkg::*;

  logic [31:0] src_setting   [NUM_CHANNELS];
  logic [31:0] dst_setting   [NUM_CHANNELS];
  logic [20:0] count_setting [NUM_CHANNELS];
  logic [10:0] control_bits  [NUM_CHANNELS];
  logic [31:0] fill_word     [NUM_CHANNELS];
  logic [31:0] cur_src       [NUM_CHANNELS];
  logic [31:0] cur_dst       [NUM_CHANNELS];
  logic [21:0] remaining     [NUM_CHANNELS];

  state_t      state, state_next;
  logic [CH_W-1:0] card_ch;
  logic        card_any;

  logic        out_free;
  assign out_free = !res_valid || res_ready;

  logic [7:0]      addr;
  logic [CH_W-1:0] dch;
  logic            dok, dfill;
  logic [7:0]      off;

  always_comb begin
    addr  = in_item.reg_addr;
    dfill = addr >= ADDR_FILL;
    if (dfill) dch = addr[3:2];
    else if (addr < 8'hBC) dch = 2'd0;
    else if (addr < 8'hC8) dch = 2'd1;
    else if (addr < 8'hD4) dch = 2'd2;
    else dch = 2'd3;
    dok = (addr >= ADDR_LO) && (addr <= ADDR_HI) && ({1'b0, dch} < 3'(NUM_CHANNELS));
    off = addr - 8'(12 * dch);
  end

  logic            tick_hit;
  logic [CH_W-1:0] tick_ch;
  always_comb begin
    tick_hit = 1'b0;
    tick_ch = '0;
    for (int c = NUM_CHANNELS - 1; c >= 0; c--) begin
      if (control_bits[c][10] && control_bits[c][8:6] == SYNC_NOW && remaining[c] != 22'd0) begin
        tick_hit = 1'b1;
        tick_ch = CH_W'(c);
      end
    end
  end

  logic card_en;
  assign card_en = control_bits[card_ch][10] && control_bits[card_ch][8:6] == SYNC_CARD;
  logic card_more;
  always_comb begin
    card_more = 1'b0;
    for (int c = 0; c < NUM_CHANNELS; c++)
      if (CH_W'(c) > card_ch && control_bits[c][10] && control_bits[c][8:6] == SYNC_CARD)
        card_more = 1'b1;
  end

  logic go;
  assign go = (state == ST_IDLE) && in_valid && out_free;
  assign in_ready = (state == ST_IDLE) && out_free;
  logic card_take;
  assign card_take = go && in_item.command == CMD_CARD;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (card_take) state_next = ST_CARD;
      ST_CARD: if (out_free && card_ch == CH_W'(NUM_CHANNELS - 1)) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    logic [21:0] rem;
    logic [21:0] reload;
    logic [31:0] sz;
    logic [31:0] ndst;
    logic [10:0] ctl;
    logic [CH_W-1:0] c;
    logic [15:0] d16;
    logic        ok;
    logic        put;
    result_t     r;
    if (rst) begin
      res_valid <= 1'b0;
      card_ch <= '0;
      card_any <= 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        src_setting[i] <= '0; dst_setting[i] <= '0; count_setting[i] <= '0;
        control_bits[i] <= '0; fill_word[i] <= '0; cur_src[i] <= '0;
        cur_dst[i] <= '0; remaining[i] <= '0;
      end
    end else begin
      put = 1'b0;
      r = '0;
      if (go && in_item.command != CMD_CARD) begin
        r.last = 1'b1;
        put = 1'b1;
        c = dch;
        d16 = in_item.write_data[15:0];
        if (in_item.command == CMD_READ) begin
          ok = dok;
          if (dok && in_item.access_word && dfill) r.read_data = fill_word[c];
          else if (dok && in_item.access_word && off == OFF_SRC) r.read_data = src_setting[c];
          else if (dok && in_item.access_word && off == OFF_CNT)
            r.read_data = {control_bits[c], count_setting[c]};
          else if (dok && !in_item.access_word && !dfill && off == OFF_HIGH)
            r.read_data = {16'd0, control_bits[c], count_setting[c][20:16]};
          else ok = 1'b0;
          r.access_error = !ok;
        end else if (in_item.command == CMD_WRITE) begin
          ok = dok;
          ctl = control_bits[c];
          if (dok && in_item.access_word && dfill) fill_word[c] <= in_item.write_data;
          else if (dok && in_item.access_word && off == OFF_SRC) src_setting[c] <= in_item.write_data;
          else if (dok && in_item.access_word && off == OFF_DST) dst_setting[c] <= in_item.write_data;
          else if (dok && in_item.access_word && off == OFF_CNT) begin
            count_setting[c] <= in_item.write_data[20:0];
            ctl = in_item.write_data[31:21];
            reload = (in_item.write_data[20:0] == 21'd0) ? COUNT_ZERO_MEANS
                     : {1'b0, in_item.write_data[20:0]};
            if (!control_bits[c][10] && ctl[10]) begin
              cur_src[c] <= {src_setting[c][31:1], 1'b0};
              cur_dst[c] <= {dst_setting[c][31:1], 1'b0};
              remaining[c] <= reload;
              if (ctl[8:6] == SYNC_NOW) ctl[4] = 1'b0;
            end
            control_bits[c] <= ctl;
          end else if (dok && !in_item.access_word && !dfill && off == OFF_CNT)
            count_setting[c] <= {count_setting[c][20:16], d16};
          else if (dok && !in_item.access_word && !dfill && off == OFF_HIGH) begin
            count_setting[c] <= {d16[4:0], count_setting[c][15:0]};
            ctl = d16[15:5];
            reload = ({d16[4:0], count_setting[c][15:0]} == 21'd0) ? COUNT_ZERO_MEANS
                     : {1'b0, d16[4:0], count_setting[c][15:0]};
            if (!control_bits[c][10] && ctl[10]) begin
              cur_src[c] <= {src_setting[c][31:1], 1'b0};
              cur_dst[c] <= {dst_setting[c][31:1], 1'b0};
              remaining[c] <= reload;
              if (ctl[8:6] == SYNC_NOW) ctl[4] = 1'b0;
            end
            control_bits[c] <= ctl;
          end else ok = 1'b0;
          r.access_error = !ok;
        end else if (tick_hit) begin
          c = tick_ch;
          ctl = control_bits[c];
          sz = ctl[5] ? 32'd4 : 32'd2;
          rem = remaining[c] - 22'd1;
          r.copy_valid = 1'b1;
          r.copy_src = cur_src[c];
          r.copy_dst = cur_dst[c];
          r.copy_is_word = ctl[5];
          cur_dst[c] <= cur_dst[c] + step_of(ctl[1:0], 1'b1, sz);
          cur_src[c] <= cur_src[c] + step_of(ctl[3:2], 1'b0, sz);
          remaining[c] <= rem;
          if (rem == 22'd0) begin
            r.irq_valid = ctl[9];
            r.irq_channel = ctl[9] ? c : '0;
            control_bits[c][10] <= 1'b0;
          end
        end
      end
      if (card_take) begin
        card_ch <= '0;
        card_any <= 1'b0;
      end
      if (state == ST_CARD && out_free) begin
        c = card_ch;
        if (card_ch != CH_W'(NUM_CHANNELS - 1)) card_ch <= card_ch + CH_W'(1);
        if (card_en) begin
          card_any <= 1'b1;
          ctl = control_bits[c];
          rem = remaining[c] - 22'd1;
          ndst = cur_dst[c] + step_of(ctl[1:0], 1'b1, 32'd4);
          r.copy_valid = 1'b1;
          r.copy_src = cur_src[c];
          r.copy_dst = cur_dst[c];
          r.copy_is_word = 1'b1;
          r.last = !card_more;
          put = 1'b1;
          cur_src[c] <= cur_src[c] + step_of(ctl[3:2], 1'b0, 32'd4);
          if (rem == 22'd0) begin
            r.irq_valid = ctl[9];
            r.irq_channel = ctl[9] ? c : '0;
            if (ctl[4]) begin
              rem = (count_setting[c] == 21'd0) ? COUNT_ZERO_MEANS
                    : {1'b0, count_setting[c]};
              if (ctl[1:0] == 2'd3) ndst = {dst_setting[c][31:1], 1'b0};
            end else control_bits[c][10] <= 1'b0;
          end
          remaining[c] <= rem;
          cur_dst[c] <= ndst;
        end else if (card_ch == CH_W'(NUM_CHANNELS - 1) && !card_any) begin
          r.last = 1'b1;
          put = 1'b1;
        end
      end
      if (put) begin
        res <= r;
        res_valid <= 1'b1;
      end else if (res_valid && res_ready) res_valid <= 1'b0;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> res_valid)
    else $error("result dropped under stall");
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_CARD) |-> !in_ready)
    else $error("accepted during card burst");
  assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res.copy_valid) |-> (res.copy_src == 32'd0 && res.copy_dst == 32'd0))
    else $error("copy fields not cleared");
endmodule
`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import fcdma_pkg::*;

  localparam int LIMIT = 400000;
  localparam int EN_BIT = 10;
  localparam int IRQ_BIT = 9;
  localparam int WORD_BIT = 5;
  localparam int REPEAT_BIT = 4;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic [1:0] s_axis_tuser = CMD_READ;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [103:0] m_axis_tdata;
  logic m_axis_tlast;

  four_channel_dma_controller u_top (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
  );

  // channel state as software and the sequencer see it
  logic [31:0] src_set[4], dst_set[4], fill_set[4], cur_src[4], cur_dst[4];
  logic [20:0] cnt_set[4];
  logic [10:0] ctl[4];
  logic [21:0] remain[4];

  result_t pending_results[$];
  int n_items, n_results, n_copies, n_irqs, n_errors, mismatches, cycles;
  bit calm;
  int stall_left;

  initial forever #5 clk = ~clk;

  function automatic logic [31:0] addr_step(logic [1:0] mode, bit is_dst, logic [31:0] size);
    case (mode)
      2'd0: return size;
      2'd1: return 32'd0 - size;
      2'd2: return 32'd0;
      default: return is_dst ? size : 32'd0;
    endcase
  endfunction

  function automatic logic [10:0] ctl_word(logic [1:0] dmode, logic [1:0] smode, bit rep,
                                           bit wide, logic [2:0] sync, bit irq, bit en);
    return {en, irq, sync, wide, rep, smode, dmode};
  endfunction

  function automatic void reload(int c);
    remain[c] = (cnt_set[c] != 0) ? {1'b0, cnt_set[c]} : COUNT_ZERO_MEANS;
  endfunction

  function automatic void set_ctl(int c, logic [10:0] v);
    bit was_on;
    was_on = ctl[c][EN_BIT];
    ctl[c] = v;
    if (!was_on && v[EN_BIT]) begin
      cur_src[c] = {src_set[c][31:1], 1'b0};
      cur_dst[c] = {dst_set[c][31:1], 1'b0};
      reload(c);
      if (ctl[c][8:6] == SYNC_NOW) ctl[c][REPEAT_BIT] = 1'b0;
    end
  endfunction

  function automatic void issue_copy(ref result_t r, input int c, input logic [31:0] size);
    r.copy_valid = 1'b1;
    r.copy_src = cur_src[c];
    r.copy_dst = cur_dst[c];
    r.copy_is_word = (size == 32'd4);
    cur_dst[c] += addr_step(ctl[c][1:0], 1'b1, size);
    cur_src[c] += addr_step(ctl[c][3:2], 1'b0, size);
    remain[c] = remain[c] - 22'd1;
  endfunction

  function automatic void predict_command(cmd_t cmd, logic [7:0] addr, bit wide,
                                          logic [31:0] data);
    result_t r;
    bit ok, fill, any;
    int c;
    logic [7:0] off;
    r = '0;
    any = 1'b0;
    ok = 1'b0;
    fill = 1'b0;
    c = 0;
    off = '0;
    if (cmd == CMD_READ || cmd == CMD_WRITE) begin
      if (addr >= ADDR_LO && addr <= ADDR_HI) begin
        ok = 1'b1;
        if (addr >= ADDR_FILL) begin
          fill = 1'b1;
          c = addr[3:2];
        end else begin
          c = addr < 8'hBC ? 0 : addr < 8'hC8 ? 1 : addr < 8'hD4 ? 2 : 3;
        end
        off = addr - 8'(12 * c);
      end
      if (ok && cmd == CMD_READ) begin
        if (wide && fill) r.read_data = fill_set[c];
        else if (wide && off == OFF_SRC) r.read_data = src_set[c];
        else if (wide && off == OFF_CNT) r.read_data = {ctl[c], cnt_set[c]};
        else if (!wide && !fill && off == OFF_HIGH) r.read_data = {16'd0, ctl[c], cnt_set[c][20:16]};
        else ok = 1'b0;
      end else if (ok) begin
        if (wide && fill) fill_set[c] = data;
        else if (wide && off == OFF_SRC) src_set[c] = data;
        else if (wide && off == OFF_DST) dst_set[c] = data;
        else if (wide && off == OFF_CNT) begin
          cnt_set[c] = data[20:0];
          set_ctl(c, data[31:21]);
        end else if (!wide && !fill && off == OFF_CNT) cnt_set[c][15:0] = data[15:0];
        else if (!wide && !fill && off == OFF_HIGH) begin
          cnt_set[c][20:16] = data[4:0];
          set_ctl(c, data[15:5]);
        end else ok = 1'b0;
      end
      if (!ok) r.read_data = '0;
      r.access_error = !ok;
      n_errors += !ok;
    end else if (cmd == CMD_TICK) begin
      for (int k = 0; k < NUM_CHANNELS; k++) begin
        if (ctl[k][EN_BIT] && ctl[k][8:6] == SYNC_NOW && remain[k] != 0) begin
          issue_copy(r, k, ctl[k][WORD_BIT] ? 32'd4 : 32'd2);
          if (remain[k] == 0) begin
            if (ctl[k][IRQ_BIT]) begin
              r.irq_valid = 1'b1;
              r.irq_channel = k[1:0];
            end
            ctl[k][EN_BIT] = 1'b0;
          end
          break;
        end
      end
    end else begin
      for (int k = 0; k < NUM_CHANNELS; k++) begin
        if (!ctl[k][EN_BIT] || ctl[k][8:6] != SYNC_CARD) continue;
        if (any) pending_results.push_back(r);
        r = '0;
        any = 1'b1;
        issue_copy(r, k, 32'd4);
        if (remain[k] == 0) begin
          if (ctl[k][IRQ_BIT]) begin
            r.irq_valid = 1'b1;
            r.irq_channel = k[1:0];
          end
          if (ctl[k][REPEAT_BIT]) begin
            reload(k);
            if (ctl[k][1:0] == 2'd3) cur_dst[k] = {dst_set[k][31:1], 1'b0};
          end else begin
            ctl[k][EN_BIT] = 1'b0;
          end
        end
      end
    end
    r.last = 1'b1;
    pending_results.push_back(r);
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(99);
    if (calm || p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  task automatic send(cmd_t cmd, logic [7:0] addr, bit wide, logic [31:0] data);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= {7'd0, data, wide, addr};
    do @(posedge clk); while (!s_axis_tready);
    predict_command(cmd, addr, wide, data);
    n_items++;
  endtask

  function automatic logic [7:0] chan_base(int c);
    return ADDR_LO + 8'(12 * c);
  endfunction

  // stop the channel, then load settings and write the new control word, which restarts it when enabled
  task automatic program_channel(int c, logic [31:0] src, logic [31:0] dst, logic [20:0] cnt,
                                 logic [10:0] cv, bit halves);
    logic [10:0] off_cv;
    off_cv = cv;
    off_cv[EN_BIT] = 1'b0;
    send(CMD_WRITE, chan_base(c) + 8'd10, 1'b0, {16'($urandom), off_cv, cnt[20:16]});
    send(CMD_WRITE, chan_base(c), 1'b1, src);
    send(CMD_WRITE, chan_base(c) + 8'd4, 1'b1, dst);
    if (halves) begin
      send(CMD_WRITE, chan_base(c) + 8'd8, 1'b0, {16'($urandom), cnt[15:0]});
      send(CMD_WRITE, chan_base(c) + 8'd10, 1'b0, {16'($urandom), cv, cnt[20:16]});
    end else begin
      send(CMD_WRITE, chan_base(c) + 8'd8, 1'b1, {cv, cnt});
    end
  endtask

  task automatic test_register_file();
    send(CMD_READ, 8'hB0, 1'b1, '0);
    send(CMD_WRITE, 8'hB0, 1'b1, 32'hFFFF_FFFF);
    send(CMD_READ, 8'hB0, 1'b1, '0);
    send(CMD_WRITE, 8'hEC, 1'b1, 32'hA5A5_5A5A);
    send(CMD_READ, 8'hEC, 1'b1, '0);
    send(CMD_WRITE, 8'hE0, 1'b0, 32'h1234_5678);
    send(CMD_READ, 8'hE4, 1'b0, '0);
    send(CMD_READ, 8'hC0, 1'b1, '0);
    send(CMD_WRITE, 8'h00, 1'b1, 32'hFFFF_FFFF);
    send(CMD_READ, 8'hFF, 1'b1, '0);
    send(CMD_READ, 8'hAF, 1'b0, '0);
    send(CMD_WRITE, 8'hF0, 1'b1, '0);
    send(CMD_WRITE, 8'hD4 + 8'd8, 1'b0, 32'hFFFF_FFFF);
    send(CMD_WRITE, 8'hD4 + 8'd10, 1'b0, 32'h0000_001F);
    send(CMD_READ, 8'hD4 + 8'd8, 1'b1, '0);
    send(CMD_READ, 8'hD4 + 8'd10, 1'b0, '0);
    send(CMD_READ, 8'hBC, 1'b0, '0);
  endtask

  task automatic test_immediate();
    program_channel(0, 32'h0000_1001, 32'h0000_2003, 21'd3,
                    ctl_word(2'd1, 2'd0, 1'b1, 1'b1, SYNC_NOW, 1'b1, 1'b1), 1'b0);
    program_channel(1, 32'hFFFF_FFFE, 32'h0000_0000, 21'd2,
                    ctl_word(2'd3, 2'd1, 1'b0, 1'b0, SYNC_NOW, 1'b1, 1'b1), 1'b1);
    repeat (6) send(CMD_TICK, 8'($urandom), 1'($urandom), $urandom);
    program_channel(2, 32'h10, 32'h20, 21'd2,
                    ctl_word(2'd2, 2'd2, 1'b0, 1'b1, 3'd3, 1'b0, 1'b1), 1'b0);
    send(CMD_TICK, '0, 1'b0, '0);
  endtask

  task automatic test_card();
    program_channel(2, 32'h0300_0000, 32'h0200_0001, 21'd2,
                    ctl_word(2'd3, 2'd2, 1'b1, 1'b0, SYNC_CARD, 1'b1, 1'b1), 1'b0);
    program_channel(3, 32'h0400_0100, 32'hFFFF_FFFC, 21'd1,
                    ctl_word(2'd0, 2'd3, 1'b0, 1'b0, SYNC_CARD, 1'b1, 1'b1), 1'b1);
    program_channel(0, 32'h8, 32'h4, 21'd0,
                    ctl_word(2'd1, 2'd1, 1'b1, 1'b1, SYNC_CARD, 1'b0, 1'b1), 1'b0);
    repeat (5) send(CMD_CARD, '0, 1'b0, '0);
    program_channel(0, 32'h0, 32'h0, 21'd0,
                    ctl_word(2'd0, 2'd0, 1'b0, 1'b0, SYNC_NOW, 1'b0, 1'b1), 1'b0);
    repeat (3) send(CMD_TICK, '0, 1'b0, '0);
    send(CMD_WRITE, 8'hBA, 1'b0, '0);
    send(CMD_WRITE, 8'hD2, 1'b0, '0);
    send(CMD_CARD, '0, 1'b0, '0);
  endtask

  task automatic test_random(int target);
    int p;
    logic [2:0] sync;
    logic [7:0] addr;
    while (n_items < target) begin
      p = $urandom_range(99);
      calm = ($urandom_range(9) == 0);
      if (p < 35) begin
        case ($urandom_range(4))
          0: sync = 3'($urandom);
          1, 2: sync = SYNC_NOW;
          default: sync = SYNC_CARD;
        endcase
        program_channel($urandom_range(3), $urandom, $urandom,
                        ($urandom_range(19) == 0) ? 21'($urandom) : 21'($urandom_range(1, 4)),
                        ctl_word(2'($urandom), 2'($urandom), 1'($urandom), 1'($urandom), sync,
                                 1'($urandom), ($urandom_range(9) != 0)),
                        1'($urandom));
        repeat ($urandom_range(1, 6))
          send($urandom_range(1) ? CMD_TICK : CMD_CARD, 8'($urandom), 1'($urandom), $urandom);
      end else if (p < 75) begin
        send($urandom_range(1) ? CMD_TICK : CMD_CARD, 8'($urandom), 1'($urandom), $urandom);
      end else begin
        addr = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(176, 239));
        send($urandom_range(1) ? CMD_READ : CMD_WRITE, addr, 1'($urandom), $urandom);
      end
    end
    calm = 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst || stall_left == 0) begin
      m_axis_tready <= !rst;
      if (!rst && !calm && $urandom_range(99) < 25)
        stall_left <= ($urandom_range(9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 3);
    end else begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end
  end

  always @(posedge clk) begin
    result_t want, got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.read_data = m_axis_tdata[31:0];
      got.access_error = m_axis_tdata[32];
      got.copy_valid = m_axis_tdata[33];
      got.copy_src = m_axis_tdata[65:34];
      got.copy_dst = m_axis_tdata[97:66];
      got.copy_is_word = m_axis_tdata[98];
      got.irq_valid = m_axis_tdata[99];
      got.irq_channel = m_axis_tdata[101:100];
      got.last = m_axis_tlast;
      n_results++;
      n_copies += got.copy_valid;
      n_irqs += got.irq_valid;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transfer on m_axis: %h", got);
      end else begin
        want = pending_results.pop_front();
        if (got.read_data !== want.read_data || got.access_error !== want.access_error ||
            got.copy_valid !== want.copy_valid || got.copy_src !== want.copy_src ||
            got.copy_dst !== want.copy_dst || got.copy_is_word !== want.copy_is_word ||
            got.irq_valid !== want.irq_valid || got.irq_channel !== want.irq_channel ||
            got.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch rd %h/%h err %b/%b cp %b/%b src %h/%h dst %h/%h w %b/%b irq %b/%b ch %0d/%0d last %b/%b",
                     want.read_data, got.read_data, want.access_error, got.access_error,
                     want.copy_valid, got.copy_valid, want.copy_src, got.copy_src,
                     want.copy_dst, got.copy_dst, want.copy_is_word, got.copy_is_word,
                     want.irq_valid, got.irq_valid, want.irq_channel, got.irq_channel,
                     want.last, got.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout with %0d results outstanding", pending_results.size());
      $display("tb: errors");
      $finish;
    end
  end

  initial begin
    for (int k = 0; k < 4; k++) begin
      src_set[k] = '0; dst_set[k] = '0; fill_set[k] = '0; cur_src[k] = '0;
      cur_dst[k] = '0; cnt_set[k] = '0; ctl[k] = '0; remain[k] = '0;
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_register_file();
    test_immediate();
    test_card();
    test_random(170);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("covered %0d commands, %0d results: %0d copy requests, %0d irqs, %0d access errors",
             n_items, n_results, n_copies, n_irqs, n_errors);
    $display("mismatches: %0d", mismatches);
    if (mismatches == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

endmodule
